// File: design/gmsp_pkg.sv
// ----------------------------------------------------------------------------
// Gaussian-modulated sine pulse: shared package
// Register map codes, fixed-point constants and pipeline sizing.
// ----------------------------------------------------------------------------
package gmsp_pkg;

    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_AMPLITUDE   = 2'd0;
    localparam logic [1:0] REG_BANDWIDTH   = 2'd1;
    localparam logic [1:0] REG_CENTRE_FREQ = 2'd2;

    localparam logic [15:0] AMP_RESET = 16'h4000;
    localparam logic [31:0] BW_RESET  = 32'h0080_0000;
    localparam logic [31:0] FC_RESET  = 32'h0100_0000;

    localparam logic [31:0] PI_Q28  = 32'h3243_F6A9;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    // exp(-1) in Q.30 exactly as the truncating series produces it.
    localparam logic [28:0] E1_Q30  = 29'd395007543;

    localparam logic [63:0] FOUR_OVER_PI_Q62 = 64'h517C_C1B7_2722_0A95;
    localparam int          DIV_BITS         = 57;
    localparam logic [DIV_BITS-1:0] DIV_NUM  = FOUR_OVER_PI_Q62[62:6];

    localparam int EXP_TERMS  = 14;
    localparam int TRIG_TERMS = 8;
    localparam int EXP_LIMIT  = 24;
    localparam int E_STEPS    = EXP_LIMIT - 1;

    typedef logic [30:0] t_q30;

endpackage

// File: design/gmsp_div.sv
// ----------------------------------------------------------------------------
// Gaussian-modulated sine pulse: delay divider
// Restoring divider, one quotient bit per cycle, giving (4/pi) / bandwidth.
// ----------------------------------------------------------------------------
module gmsp_div
    import gmsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_divisor,
    output logic [DIV_BITS-1:0] o_quot,
    output logic                o_busy
);

    localparam int CNT_W = $clog2(DIV_BITS);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [31:0]         r_rem;
    logic [DIV_BITS-1:0] r_q;

    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_trial = {r_rem, r_q[DIV_BITS-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_ge    = w_trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_q    <= DIV_NUM;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
            r_q   <= {r_q[DIV_BITS-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_quot = r_q;
    assign o_busy = r_busy;

endmodule

// File: design/gmsp_series.sv
// ----------------------------------------------------------------------------
// Gaussian-modulated sine pulse: series pipeline
// Alternating power series, two register stages per term, clamped to [0, 1].
// ----------------------------------------------------------------------------
module gmsp_series
    import gmsp_pkg::*;
#(
    parameter int P_TERMS = EXP_TERMS,
    parameter bit P_TRIG  = 1'b0
) (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [31:0] i_mul,
    input  t_q30        i_term,
    input  logic        i_cos,
    output t_q30        o_sum
);

    logic [31:0]        r_am   [1:P_TERMS];
    logic [31:0]        r_x    [1:P_TERMS];
    logic signed [34:0] r_as   [1:P_TERMS];
    logic               r_ac   [1:P_TERMS];
    logic [31:0]        r_mul  [1:P_TERMS];
    t_q30               r_term [1:P_TERMS];
    logic signed [34:0] r_sum  [1:P_TERMS];
    logic               r_cos  [1:P_TERMS];
    t_q30               r_out;

    logic [31:0]        w_min  [1:P_TERMS];
    t_q30               w_tin  [1:P_TERMS];
    logic signed [34:0] w_sin  [1:P_TERMS];
    logic               w_cin  [1:P_TERMS];
    logic [31:0]        w_xn   [1:P_TERMS];
    t_q30               w_q    [1:P_TERMS];
    logic signed [34:0] w_sn   [1:P_TERMS];

    for (genvar j = 1; j <= P_TERMS; j++) begin : g_term
        localparam int unsigned DEN_S = P_TRIG ? (2 * j) * (2 * j + 1) : j;
        localparam int unsigned DEN_C = P_TRIG ? (2 * j - 1) * (2 * j) : j;
        localparam int unsigned SH_S  = 32 + $clog2(DEN_S);
        localparam int unsigned SH_C  = 32 + $clog2(DEN_C);
        localparam longint unsigned MS_L =
            ((64'd1 << SH_S) + 64'(DEN_S) - 64'd1) / 64'(DEN_S);
        localparam longint unsigned MC_L =
            ((64'd1 << SH_C) + 64'(DEN_C) - 64'd1) / 64'(DEN_C);
        localparam logic [32:0] M_S = MS_L[32:0];
        localparam logic [32:0] M_C = MC_L[32:0];
        localparam bit          SUB = (j % 2) == 1;

        logic [62:0] w_prod;
        logic [64:0] w_qs;
        logic [64:0] w_qc;

        if (j == 1) begin : g_first
            assign w_min[j] = i_mul;
            assign w_tin[j] = i_term;
            assign w_sin[j] = $signed({4'b0, i_term});
            assign w_cin[j] = i_cos;
        end else begin : g_next
            assign w_min[j] = r_mul[j-1];
            assign w_tin[j] = r_term[j-1];
            assign w_sin[j] = r_sum[j-1];
            assign w_cin[j] = r_cos[j-1];
        end

        assign w_prod  = w_tin[j] * w_min[j];
        assign w_xn[j] = w_prod[61:30];
        assign w_qs    = r_x[j] * M_S;
        assign w_qc    = r_x[j] * M_C;
        assign w_q[j]  = r_ac[j] ? t_q30'(w_qc >> SH_C) : t_q30'(w_qs >> SH_S);
        assign w_sn[j] = SUB ? r_as[j] - $signed({4'b0, w_q[j]})
                             : r_as[j] + $signed({4'b0, w_q[j]});
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int j = 1; j <= P_TERMS; j++) begin
                r_am[j]   <= w_min[j];
                r_x[j]    <= w_xn[j];
                r_as[j]   <= w_sin[j];
                r_ac[j]   <= w_cin[j];
                r_mul[j]  <= r_am[j];
                r_term[j] <= w_q[j];
                r_sum[j]  <= w_sn[j];
                r_cos[j]  <= r_ac[j];
            end
            if (r_sum[P_TERMS] < 0) begin
                r_out <= '0;
            end else if (r_sum[P_TERMS] > $signed({4'b0, ONE_Q30})) begin
                r_out <= ONE_Q30;
            end else begin
                r_out <= r_sum[P_TERMS][30:0];
            end
        end
    end

    assign o_sum = r_out;

endmodule

// File: design/gaussian_modulated_sine_pulse_core.sv
// ----------------------------------------------------------------------------
// Gaussian-modulated sine pulse core
// One pulse sample per input time word, fully pipelined.
// ----------------------------------------------------------------------------
// The input stream carries one sample time (unsigned Q16.16) per word. Each
// word gives one output word: the pulse value (signed Q1.15) in tdata and the
// saturation flag in tuser. Amplitude, bandwidth and centre frequency are set
// through the register port; the user must write them only while no word is
// in flight, which the block itself does not enforce. A new word may enter
// every cycle unless the output stalls, the divider is busy or a register is
// written. The exp series and the exp(-1) chain for the Gaussian set the depth.
// After reset, and after each bandwidth write, a bit-serial divider computes
// the pulse delay; s_axis_tready is low until it is done.
// When the receiver stalls with a word waiting at the output, the pipeline
// holds; words still enter while the output stage is empty.
// Reset returns the registers to amplitude 1.0, bandwidth 0.5 and centre
// frequency 1.0, and empties the pipeline.
// ----------------------------------------------------------------------------
module gaussian_modulated_sine_pulse_core
    import gmsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,    // sample_time
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,    // sample_value
    output logic [0:0]        m_axis_tuser,    // clipped
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LAT_EXP  = 2 * EXP_TERMS + 1;
    localparam int LAT_TRIG = 2 * TRIG_TERMS + 1;
    localparam int ST_G     = 3;
    localparam int ST_GE    = ST_G + LAT_EXP + E_STEPS;
    localparam int ST_T     = 5;
    localparam int ST_TE    = ST_T + LAT_TRIG;
    localparam int S_WAIT   = ST_GE - ST_TE;
    localparam int Q_WAIT   = ST_GE - ST_T;
    localparam int LAST     = ST_GE + 3;

    logic signed [15:0] r_amp;
    logic [31:0]        r_bw;
    logic [31:0]        r_fc;

    logic        w_wr;
    logic [1:0]  w_idx;
    logic        w_ce;
    logic        w_accept;
    logic        w_busy;
    logic [DIV_BITS-1:0] w_d;

    logic [LAST:0] r_vld;

    logic [31:0] r_t;
    logic [63:0] r_m;
    logic        r_gfar2;
    logic [31:0] r_xs;
    logic        r_gfar3;
    logic [35:0] r_z;
    logic [4:0]  r_gn_d [1:LAT_EXP];
    logic        r_gf_d [1:LAT_EXP];
    t_q30        r_eg   [1:E_STEPS];
    logic [4:0]  r_en   [1:E_STEPS];
    logic        r_ef   [1:E_STEPS];

    logic [63:0] r_u;
    logic [59:0] r_pl;
    logic [27:0] r_phh;
    logic [31:0] r_ph;
    t_q30        r_th;
    logic [1:0]  r_q4;
    logic [31:0] r_th2;
    t_q30        r_th5;
    logic [1:0]  r_q5;
    logic        r_tn_d [1:Q_WAIT];
    t_q30        r_s_d  [1:S_WAIT];

    t_q30        r_mag;
    logic        r_neg6;
    logic [16:0] r_y;
    logic        r_neg7;
    logic [15:0] r_val;
    logic        r_clip;

    logic [42:0] w_mr;
    logic [66:0] w_xp;
    logic [66:0] w_xr;
    logic [31:0] w_ax;
    logic [63:0] w_zp;
    logic [64:0] w_zr;
    logic        w_far3;
    t_q30        w_g0;
    t_q30        w_eg_in [1:E_STEPS];
    logic [4:0]  w_en_in [1:E_STEPS];
    logic        w_ef_in [1:E_STEPS];
    t_q30        w_eg_nx [1:E_STEPS];
    logic [59:0] w_ph;
    logic [55:0] w_ps;
    logic [61:0] w_tp;
    logic [61:0] w_tr;
    logic [61:0] w_t2;
    t_q30        w_s;
    t_q30        w_gf;
    logic [61:0] w_mp;
    logic [61:0] w_mrd;
    logic [16:0] w_amag;
    logic [47:0] w_yp;
    logic [47:0] w_yr;
    logic [15:0] w_val;
    logic        w_clip;

    // Register port
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp <= AMP_RESET;
            r_bw  <= BW_RESET;
            r_fc  <= FC_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_AMPLITUDE:   r_amp <= pwdata[15:0];
                REG_BANDWIDTH:   r_bw  <= pwdata;
                REG_CENTRE_FREQ: r_fc  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_AMPLITUDE:   prdata = {16'h0, r_amp};
            REG_BANDWIDTH:   prdata = r_bw;
            REG_CENTRE_FREQ: prdata = r_fc;
            default:         prdata = '0;
        endcase
    end

    gmsp_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_wr && (w_idx == REG_BANDWIDTH)),
        .i_divisor (r_bw),
        .o_quot    (w_d),
        .o_busy    (w_busy)
    );

    // Handshake and valid pipeline
    assign w_ce          = ~r_vld[LAST] | m_axis_tready;
    assign s_axis_tready = w_ce & ~w_busy & ~w_wr;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LAST-1:0], w_accept};
        end
    end

    // Gaussian front end
    assign w_mr   = {1'b0, r_m[41:0]} + 43'd128;
    assign w_xp   = w_mr[42:8] * PI_Q28;
    assign w_xr   = w_xp + 67'h8000_0000;
    assign w_ax   = (r_xs >= 32'h4000_0000) ? r_xs - 32'h4000_0000
                                            : 32'h4000_0000 - r_xs;
    assign w_zp   = w_ax * w_ax;
    assign w_zr   = {1'b0, w_zp} + 65'h800_0000;
    assign w_far3 = r_gfar3 | (r_z[35:28] >= 8'(EXP_LIMIT));

    gmsp_series #(
        .P_TERMS (EXP_TERMS),
        .P_TRIG  (1'b0)
    ) u_exp (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_mul  ({2'b00, r_z[27:0], 2'b00}),
        .i_term (ONE_Q30),
        .i_cos  (1'b0),
        .o_sum  (w_g0)
    );

    for (genvar i = 1; i <= E_STEPS; i++) begin : g_estep
        logic [59:0] w_ep;
        logic [59:0] w_epr;

        if (i == 1) begin : g_first
            assign w_eg_in[i] = w_g0;
            assign w_en_in[i] = r_gn_d[LAT_EXP];
            assign w_ef_in[i] = r_gf_d[LAT_EXP];
        end else begin : g_next
            assign w_eg_in[i] = r_eg[i-1];
            assign w_en_in[i] = r_en[i-1];
            assign w_ef_in[i] = r_ef[i-1];
        end

        assign w_ep       = w_eg_in[i] * E1_Q30;
        assign w_epr      = w_ep + 60'h2000_0000;
        assign w_eg_nx[i] = (5'(i - 1) < w_en_in[i]) ? {1'b0, w_epr[59:30]} : w_eg_in[i];
    end

    // Carrier phase and angle
    assign w_ph = r_u[55:28] * r_fc;
    assign w_ps = r_pl[55:0] + {r_phh, 28'h0} + 56'h80_0000;
    assign w_tp = r_ph[29:0] * PI_Q28;
    assign w_tr = w_tp + 62'h1000_0000;
    assign w_t2 = r_th * r_th;

    gmsp_series #(
        .P_TERMS (TRIG_TERMS),
        .P_TRIG  (1'b1)
    ) u_trig (
        .i_clk  (i_clk),
        .i_ce   (w_ce),
        .i_mul  (r_th2),
        .i_term (r_q5[0] ? ONE_Q30 : r_th5),
        .i_cos  (r_q5[0]),
        .o_sum  (w_s)
    );

    // Product, scaling and saturation
    assign w_gf   = r_ef[E_STEPS] ? '0 : r_eg[E_STEPS];
    assign w_mp   = w_gf * r_s_d[S_WAIT];
    assign w_mrd  = w_mp + 62'h2000_0000;
    assign w_amag = r_amp[15] ? 17'd0 - {r_amp[15], r_amp} : {1'b0, r_amp};
    assign w_yp   = w_amag * r_mag;
    assign w_yr   = w_yp + 48'h1000_0000;

    always_comb begin
        w_val  = '0;
        w_clip = 1'b0;
        if (r_bw == 32'd0 || r_y == 17'd0) begin
            w_val = '0;
        end else if (r_neg7) begin
            if (r_y > 17'd32768) begin
                w_val  = 16'h8000;
                w_clip = 1'b1;
            end else begin
                w_val = 16'(17'd0 - r_y);
            end
        end else begin
            if (r_y > 17'd32767) begin
                w_val  = 16'h7FFF;
                w_clip = 1'b1;
            end else begin
                w_val = r_y[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_t     <= s_axis_tdata;
            r_m     <= r_t * r_bw;
            r_gfar2 <= |r_m[63:42];
            r_xs    <= w_xr[63:32];
            r_gfar3 <= r_gfar2;
            r_z     <= w_zr[63:28];

            r_gn_d[1] <= r_z[32:28];
            r_gf_d[1] <= w_far3;
            for (int k = 2; k <= LAT_EXP; k++) begin
                r_gn_d[k] <= r_gn_d[k-1];
                r_gf_d[k] <= r_gf_d[k-1];
            end
            for (int k = 1; k <= E_STEPS; k++) begin
                r_eg[k] <= w_eg_nx[k];
                r_en[k] <= w_en_in[k];
                r_ef[k] <= w_ef_in[k];
            end

            r_u   <= {16'h0, r_t, 16'h0} - {7'h0, w_d};
            r_pl  <= r_u[27:0] * r_fc;
            r_phh <= w_ph[27:0];
            r_ph  <= w_ps[55:24];
            r_th  <= w_tr[59:29];
            r_q4  <= r_ph[31:30];
            r_th2 <= w_t2[61:30];
            r_th5 <= r_th;
            r_q5  <= r_q4;

            r_tn_d[1] <= r_q5[1];
            for (int k = 2; k <= Q_WAIT; k++) begin
                r_tn_d[k] <= r_tn_d[k-1];
            end
            r_s_d[1] <= w_s;
            for (int k = 2; k <= S_WAIT; k++) begin
                r_s_d[k] <= r_s_d[k-1];
            end

            r_mag  <= w_mrd[60:30];
            r_neg6 <= r_tn_d[Q_WAIT] ^ r_amp[15];
            r_y    <= w_yr[45:29];
            r_neg7 <= r_neg6;
            r_val  <= w_val;
            r_clip <= w_clip;
        end
    end

    assign m_axis_tvalid   = r_vld[LAST];
    assign m_axis_tdata    = r_val;
    assign m_axis_tuser[0] = r_clip;

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready)
        else $error("Word accepted while the delay divider is running.");

    a_zero_bandwidth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_bw == 32'd0) |-> (m_axis_tdata == 16'd0 && !m_axis_tuser[0]))
        else $error("Zero bandwidth gave a non-zero word.");

    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0])
            |-> (m_axis_tdata == 16'h7FFF || m_axis_tdata == 16'h8000))
        else $error("Clip flag set on a value away from the rails.");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ce |=> (r_vld == $past(r_vld)))
        else $error("Pipeline moved during an output stall.");

endmodule
